@@ hw/rtl/pstc_pkg.sv @@
// ----------------------------------------------------------------------------
// pstc_pkg
// Shared widths, calibration register map and payload types for the
// temperature compensation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package pstc_pkg;

	// field widths
	localparam int RAW_W  = 16;
	localparam int CAL_W  = 16;
	localparam int DIFF_W = RAW_W + 1;          // raw - ac6
	localparam int PROD_W = 2 * DIFF_W;         // exact product
	localparam int X1_W   = 18;                 // (prod >>> 15) stays within +-2^17
	localparam int DEN_W  = X1_W + 1;           // x1 + md
	localparam int DMAG_W = DEN_W - 1;          // |den| < 2^18
	localparam int NMAG_W = 27;                 // |mc << 11| <= 2^26
	localparam int B5_W   = 28;
	localparam int TEMP_W = 24;

	// constants of the compensation formula
	localparam int SHIFT_X1 = 15;
	localparam int SHIFT_MC = 11;
	localparam int ROUND_C  = 8;
	localparam int SHIFT_T  = 4;

	// divider: quotient bits resolved per stage
	localparam int DIV_BITS_DEF = 3;

	// register port
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	typedef enum logic [1:0] {
		REG_AC5 = 2'd0,
		REG_AC6 = 2'd1,
		REG_MC  = 2'd2,
		REG_MD  = 2'd3
	} reg_idx_t;

	localparam logic [CAL_W-1:0]        RST_AC5 = 16'd32757;
	localparam logic [CAL_W-1:0]        RST_AC6 = 16'd23153;
	localparam logic signed [CAL_W-1:0] RST_MC  = -16'sd8711;
	localparam logic signed [CAL_W-1:0] RST_MD  = 16'sd2868;

	typedef struct packed {
		logic [CAL_W-1:0]        ac5;
		logic [CAL_W-1:0]        ac6;
		logic signed [CAL_W-1:0] mc;
		logic signed [CAL_W-1:0] md;
	} cal_t;

	// item as it travels through the divider
	typedef struct packed {
		logic [NMAG_W-1:0]       dq;   // dividend bits out at the top, quotient bits in below
		logic [DMAG_W-1:0]       rem;
		logic [DMAG_W-1:0]       dsr;
		logic                    neg;
		logic                    err;
		logic signed [X1_W-1:0]  x1;
	} div_pl_t;

endpackage

`default_nettype wire

@@ hw/rtl/pressure_sensor_temp_compensation_unit.sv @@
// ----------------------------------------------------------------------------
// pressure_sensor_temp_compensation_unit
// Barometric-sensor temperature compensation: raw reading in, temperature in
// tenths of a degree and b5 out, with calibration held in four APB registers.
//
//   channel  | signals                                  | dir
//   ---------+------------------------------------------+-----
//   input    | in_valid, in_ready, raw_temp             | in
//   result   | out_valid, out_ready, temp_tenths,       | out
//            | b5_term, div_error                       |
//   config   | psel, penable, pwrite, paddr, pwdata,    | in
//            | prdata, pready                           |
//
// One item per cycle while out_ready is high. The pipelined divider resolves
// DIV_BITS quotient bits in each of its stages.
// arst_n clears every valid bit and loads the calibration defaults.
// With out_ready low the result holds and earlier stages keep filling empty
// slots; in_ready drops only once every stage holds an item.
// ----------------------------------------------------------------------------
`default_nettype none

module pressure_sensor_temp_compensation_unit
	import pstc_pkg::*;
#(
	parameter int DIV_BITS = DIV_BITS_DEF
)
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [RAW_W-1:0]    raw_temp,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic signed [TEMP_W-1:0] temp_tenths,
	output logic signed [B5_W-1:0]   b5_term,
	output logic                     div_error,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [ADDR_W-1:0]   paddr,
	input  wire logic [DATA_W-1:0]   pwdata,
	output logic [DATA_W-1:0]        prdata,
	output logic                     pready
);

	localparam int NSTG = (NMAG_W + DIV_BITS - 1) / DIV_BITS;

	cal_t     cal_q;
	reg_idx_t idx;
	logic     wr_en;

	logic    dv_valid [NSTG+1];
	logic    dv_ready [NSTG+1];
	div_pl_t dv_pl    [NSTG+1];

	// ---------------- calibration registers ----------------
	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q.ac5 <= RST_AC5;
			cal_q.ac6 <= RST_AC6;
			cal_q.mc  <= RST_MC;
			cal_q.md  <= RST_MD;
		end else if (wr_en) begin
			unique case (idx)
				REG_AC5: cal_q.ac5 <= pwdata[CAL_W-1:0];
				REG_AC6: cal_q.ac6 <= pwdata[CAL_W-1:0];
				REG_MC:  cal_q.mc  <= $signed(pwdata[CAL_W-1:0]);
				REG_MD:  cal_q.md  <= $signed(pwdata[CAL_W-1:0]);
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_AC5: prdata = DATA_W'(cal_q.ac5);
			REG_AC6: prdata = DATA_W'(cal_q.ac6);
			REG_MC:  prdata = DATA_W'({1'b0, cal_q.mc});
			REG_MD:  prdata = DATA_W'({1'b0, cal_q.md});
		endcase
	end

	// ---------------- datapath ----------------
	pstc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cal       (cal_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.raw_temp  (raw_temp),
		.out_valid (dv_valid[0]),
		.out_ready (dv_ready[0]),
		.out_pl    (dv_pl[0])
	);

	for (genvar k = 0; k < NSTG; k++) begin : g_div
		pstc_div_stage #(
			.DIV_BITS (DIV_BITS),
			.STAGE    (k)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (dv_valid[k]),
			.in_ready  (dv_ready[k]),
			.in_pl     (dv_pl[k]),
			.out_valid (dv_valid[k+1]),
			.out_ready (dv_ready[k+1]),
			.out_pl    (dv_pl[k+1])
		);
	end

	pstc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (dv_valid[NSTG]),
		.in_ready    (dv_ready[NSTG]),
		.in_pl       (dv_pl[NSTG]),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.temp_tenths (temp_tenths),
		.b5_term     (b5_term),
		.div_error   (div_error)
	);

`ifndef SYNTH
	// input side stalls only when the whole pipe is full behind a held result
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled with room in the pipeline");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && div_error |-> temp_tenths == '0 && b5_term == '0)
		else $error("zero-divisor result not cleared");

	// temperature is b5 divided by sixteen, rounded
	a_temp_from_b5: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !div_error |->
			temp_tenths == TEMP_W'((b5_term + B5_W'(ROUND_C)) >>> SHIFT_T))
		else $error("temperature inconsistent with b5");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/pstc_front.sv @@
// ----------------------------------------------------------------------------
// pstc_front
// Front end: raw offset, calibration product, x1 and divisor, then the
// magnitudes and sign that the divider works on. Four register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module pstc_front
	import pstc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cal_t             cal,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [RAW_W-1:0] raw_temp,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output div_pl_t               out_pl
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	logic signed [DIFF_W-1:0] diff_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [X1_W-1:0]   x1_s3;
	logic signed [DEN_W-1:0]  den_s3;
	div_pl_t                  pl_s4;

	logic signed [DIFF_W-1:0] diff_d;
	logic signed [DIFF_W-1:0] ac5_sx;
	logic signed [PROD_W-1:0] prod_d;
	logic signed [X1_W-1:0]   x1_d;
	logic signed [DEN_W-1:0]  den_d;
	logic signed [NMAG_W-1:0] num_d;
	logic [NMAG_W-1:0]        nmag_d;
	logic [DEN_W-1:0]         dneg_d;
	div_pl_t                  pl_d;

	// a slot takes a new item when empty or when its own item moves on
	assign rdy4     = ~v_s4 | out_ready;
	assign rdy3     = ~v_s3 | rdy4;
	assign rdy2     = ~v_s2 | rdy3;
	assign rdy1     = ~v_s1 | rdy2;
	assign in_ready = rdy1;

	assign diff_d = $signed({1'b0, raw_temp}) - $signed({1'b0, cal.ac6});
	assign ac5_sx = $signed({1'b0, cal.ac5});
	assign prod_d = diff_s1 * ac5_sx;

	assign x1_d  = prod_s2[SHIFT_X1 +: X1_W];
	assign den_d = DEN_W'(x1_d) + DEN_W'(cal.md);

	always_comb begin
		num_d       = NMAG_W'(cal.mc) <<< SHIFT_MC;
		nmag_d      = num_d[NMAG_W-1] ? NMAG_W'(-num_d) : NMAG_W'(num_d);
		dneg_d      = DEN_W'(-den_s3);
		pl_d.dq     = nmag_d;
		pl_d.rem    = '0;
		pl_d.dsr    = den_s3[DEN_W-1] ? dneg_d[DMAG_W-1:0] : den_s3[DMAG_W-1:0];
		pl_d.neg    = num_d[NMAG_W-1] ^ den_s3[DEN_W-1];
		pl_d.err    = (den_s3 == '0);
		pl_d.x1     = x1_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) diff_s1 <= diff_d;
		if (rdy2 && v_s1)     prod_s2 <= prod_d;
		if (rdy3 && v_s2) begin
			x1_s3  <= x1_d;
			den_s3 <= den_d;
		end
		if (rdy4 && v_s3)     pl_s4 <= pl_d;
	end

	assign out_valid = v_s4;
	assign out_pl    = pl_s4;

endmodule

`default_nettype wire

@@ hw/rtl/pstc_div_stage.sv @@
// ----------------------------------------------------------------------------
// pstc_div_stage
// One stage of the unsigned restoring divider: resolves DIV_BITS quotient
// bits, then registers the item.
// ----------------------------------------------------------------------------
`default_nettype none

module pstc_div_stage
	import pstc_pkg::*;
#(
	parameter int DIV_BITS = DIV_BITS_DEF,
	parameter int STAGE    = 0
)
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	input  wire div_pl_t in_pl,
	output logic         out_valid,
	input  wire logic    out_ready,
	output div_pl_t      out_pl
);

	localparam int NSTG = (NMAG_W + DIV_BITS - 1) / DIV_BITS;
	localparam int PAD  = NSTG * DIV_BITS - NMAG_W;

	logic    vld_q;
	div_pl_t pl_q;
	div_pl_t pl_d;
	logic [DMAG_W:0] rem_w;

	assign in_ready = ~vld_q | out_ready;

	always_comb begin
		pl_d  = in_pl;
		rem_w = '0;
		for (int j = 0; j < DIV_BITS; j++) begin
			// leading steps past the padded top of the dividend do nothing
			if (STAGE * DIV_BITS + j >= PAD) begin
				rem_w   = {pl_d.rem, pl_d.dq[NMAG_W-1]};
				pl_d.dq = {pl_d.dq[NMAG_W-2:0], 1'b0};
				if (rem_w >= {1'b0, pl_d.dsr}) begin
					rem_w      = rem_w - {1'b0, pl_d.dsr};
					pl_d.dq[0] = 1'b1;
				end
				pl_d.rem = rem_w[DMAG_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (in_ready) begin
			vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) pl_q <= pl_d;
	end

	assign out_valid = vld_q;
	assign out_pl    = pl_q;

`ifndef SYNTH
	// partial remainder never reaches the divisor on a live item
	a_rem_below_dsr: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q && !pl_q.err |-> pl_q.rem < pl_q.dsr)
		else $error("divider remainder not below divisor");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/pstc_back.sv @@
// ----------------------------------------------------------------------------
// pstc_back
// Back end: signs the quotient, adds x1 to form b5, rounds to tenths and
// holds the result in the output register. Three register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module pstc_back
	import pstc_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire div_pl_t             in_pl,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic signed [TEMP_W-1:0] temp_tenths,
	output logic signed [B5_W-1:0]   b5_term,
	output logic                     div_error
);

	logic v_s1, v_s2, v_s3;
	logic rdy1, rdy2, rdy3;

	logic signed [B5_W-1:0]   x2_s1;
	logic signed [X1_W-1:0]   x1_s1;
	logic                     err_s1;
	logic signed [B5_W-1:0]   b5_s2;
	logic                     err_s2;
	logic signed [TEMP_W-1:0] temp_s3;
	logic signed [B5_W-1:0]   b5_s3;
	logic                     err_s3;

	logic signed [B5_W-1:0] q_d;
	logic signed [B5_W-1:0] sum_d;

	assign rdy3     = ~v_s3 | out_ready;
	assign rdy2     = ~v_s2 | rdy3;
	assign rdy1     = ~v_s1 | rdy2;
	assign in_ready = rdy1;

	assign q_d   = $signed({1'b0, in_pl.dq});
	assign sum_d = b5_s2 + B5_W'(ROUND_C);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			x2_s1  <= in_pl.neg ? -q_d : q_d;
			x1_s1  <= in_pl.x1;
			err_s1 <= in_pl.err;
		end
		if (rdy2 && v_s1) begin
			b5_s2  <= x2_s1 + B5_W'(x1_s1);
			err_s2 <= err_s1;
		end
		if (rdy3 && v_s2) begin
			// zero divisor: report zeros
			temp_s3 <= err_s2 ? '0 : sum_d[SHIFT_T +: TEMP_W];
			b5_s3   <= err_s2 ? '0 : b5_s2;
			err_s3  <= err_s2;
		end
	end

	assign out_valid   = v_s3;
	assign temp_tenths = temp_s3;
	assign b5_term     = b5_s3;
	assign div_error   = err_s3;

endmodule

`default_nettype wire
